// ===== hw/rtl/spp_pkg.sv =====
`timescale 1ns / 1ps

package spp_pkg;

    // sizes of the stores
    localparam int MAX_BINS  = 1024;
    localparam int MAX_PEAKS = 64;
    localparam int BIN_AW    = $clog2(MAX_BINS);
    localparam int SLOT_AW   = $clog2(MAX_PEAKS);
    localparam int CNT_W     = SLOT_AW + 1;

    // field widths
    localparam int VAL_W      = 24;
    localparam int HZ_W       = 16;
    localparam int FREQ_W     = 26;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PEAKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HZ        = 1'b1;
    localparam logic [CNT_W-1:0]     MP_RESET      = 7'd16;
    localparam logic [HZ_W-1:0]      HZ_RESET      = 16'd5504;
    localparam logic [CNT_W-1:0]     LIM_LOW       = 7'd2;
    localparam logic [CNT_W-1:0]     LIM_HIGH      = CNT_W'(MAX_PEAKS);

    typedef struct packed {
        logic [VAL_W-1:0] bin_value;
        logic             last_bin;
    } t_in_word;

    typedef struct packed {
        logic [SLOT_AW-1:0] slot;
        logic [9:0]         peak_bin;
        logic [FREQ_W-1:0]  peak_freq;
        logic [VAL_W-1:0]   peak_power;
        logic [CNT_W-1:0]   peak_count;
        logic [FREQ_W-1:0]  max_freq;
        logic [FREQ_W-1:0]  min_freq;
        logic               last;
    } t_out_word;

    // one stored peak
    typedef struct packed {
        logic [BIN_AW-1:0] bin;
        logic [VAL_W-1:0]  pow;
    } t_pk_ent;

    // write request into the peak store
    typedef struct packed {
        logic               we;
        logic [SLOT_AW-1:0] addr;
        t_pk_ent            ent;
    } t_pk_wr;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAX,
        S_WALK,
        S_SCAN,
        S_TAIL,
        S_FMAX,
        S_FMIN,
        S_EMIT,
        S_DRAIN
    } t_state;

endpackage

// ===== hw/rtl/spp_bin_mem.sv =====
`timescale 1ns / 1ps

module spp_bin_mem
    import spp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [BIN_AW-1:0] i_waddr,
    input  logic [VAL_W-1:0]  i_wdata,
    input  logic [BIN_AW-1:0] i_raddr,
    output logic [VAL_W-1:0]  o_rdata
);

    logic [VAL_W-1:0] r_mem [MAX_BINS];
    logic [VAL_W-1:0] r_rd;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_mem[i_raddr];
    end

    assign o_rdata = r_rd;

endmodule

// ===== hw/rtl/spp_peak_mem.sv =====
`timescale 1ns / 1ps

module spp_peak_mem
    import spp_pkg::*;
(
    input  logic               i_clk,
    input  t_pk_wr             i_wr,
    input  logic [SLOT_AW-1:0] i_raddr,
    output t_pk_ent            o_rdata
);

    t_pk_ent r_mem [MAX_PEAKS];
    t_pk_ent r_rd;

    // peak slots, written during the scan and read out slot by slot
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.ent;
        end
        r_rd <= r_mem[i_raddr];
    end

    assign o_rdata = r_rd;

endmodule

// ===== hw/rtl/spp_mul.sv =====
`timescale 1ns / 1ps

module spp_mul
    import spp_pkg::*;
(
    input  logic              i_clk,
    input  logic [BIN_AW-1:0] i_a,
    input  logic [HZ_W-1:0]   i_b,
    output logic [FREQ_W-1:0] o_p
);

    logic [FREQ_W-1:0] r_p;

    // bin times frequency step, registered
    always_ff @(posedge i_clk) begin
        r_p <= FREQ_W'(i_a) * FREQ_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== hw/rtl/spp_seq.sv =====
`timescale 1ns / 1ps

module spp_seq
    import spp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_in_word           i_word,
    output logic               o_busy,
    input  logic [CNT_W-1:0]   i_lim,
    output logic               o_bm_we,
    output logic [BIN_AW-1:0]  o_bm_waddr,
    output logic [VAL_W-1:0]   o_bm_wdata,
    output logic [BIN_AW-1:0]  o_bm_raddr,
    input  logic [VAL_W-1:0]   i_bm_rdata,
    output t_pk_wr             o_pk_wr,
    output logic [SLOT_AW-1:0] o_pk_raddr,
    input  t_pk_ent            i_pk_rdata,
    output logic [BIN_AW-1:0]  o_mul_a,
    input  logic [FREQ_W-1:0]  i_prod,
    output logic               o_strobe,
    output t_out_word          o_word
);

    // control state
    t_state             r_state, n_state;
    logic [BIN_AW:0]    r_bin_count, n_bin_count;
    logic               r_iss, n_iss;
    logic               r_rv, n_rv;
    logic               r_s1_vld, n_s1_vld;
    logic               r_o_vld, n_o_vld;

    // payload state
    logic [BIN_AW-1:0]  r_last, n_last;
    logic [BIN_AW-1:0]  r_ra, n_ra;
    logic [BIN_AW-1:0]  r_ri, n_ri;
    logic [VAL_W-1:0]   r_best, n_best;
    logic [BIN_AW-1:0]  r_pm, n_pm;
    logic [BIN_AW-1:0]  r_sm1, n_sm1;
    logic [BIN_AW-1:0]  r_start, n_start;
    logic [VAL_W-1:0]   r_w0, n_w0;
    logic [VAL_W-1:0]   r_w1, n_w1;
    logic [VAL_W-1:0]   r_vmax, n_vmax;
    logic [VAL_W-1:0]   r_vmin, n_vmin;
    logic [BIN_AW-1:0]  r_emax, n_emax;
    logic [BIN_AW-1:0]  r_emin, n_emin;
    logic [CNT_W-1:0]   r_c, n_c;
    logic [CNT_W-1:0]   r_k, n_k;
    logic [FREQ_W-1:0]  r_max_freq, n_max_freq;
    logic [FREQ_W-1:0]  r_min_freq, n_min_freq;
    logic [SLOT_AW-1:0] r_s1_k, n_s1_k;
    logic               r_s1_last, n_s1_last;
    logic [SLOT_AW-1:0] r_o_slot, n_o_slot;
    logic [BIN_AW-1:0]  r_o_bin, n_o_bin;
    logic [VAL_W-1:0]   r_o_pow, n_o_pow;
    logic               r_o_last, n_o_last;

    logic               accept;
    logic               full;
    logic               issue;
    logic               stop;
    logic               ev_en;
    logic [VAL_W-1:0]   ev_prev, ev_cur, ev_next;
    logic [BIN_AW-1:0]  ev_idx;
    logic [BIN_AW-1:0]  s1_bin;
    logic [VAL_W-1:0]   s1_pow;

    assign o_busy = (r_state != S_IDLE);
    assign accept = i_start && (r_state == S_IDLE);
    assign full   = r_bin_count[BIN_AW];

    // bins load straight into the store
    assign o_bm_we    = accept && !full;
    assign o_bm_waddr = r_bin_count[BIN_AW-1:0];
    assign o_bm_wdata = i_word.bin_value;
    assign o_bm_raddr = r_ra;

    // slot 0 always reads as zero
    assign s1_bin = (r_s1_k == '0) ? '0 : i_pk_rdata.bin;
    assign s1_pow = (r_s1_k == '0) ? '0 : i_pk_rdata.pow;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_bin_count = r_bin_count;
        n_iss       = r_iss;
        n_s1_vld    = 1'b0;
        n_last      = r_last;
        n_ra        = r_ra;
        n_best      = r_best;
        n_pm        = r_pm;
        n_sm1       = r_sm1;
        n_start     = r_start;
        n_w0        = r_w0;
        n_w1        = r_w1;
        n_vmax      = r_vmax;
        n_vmin      = r_vmin;
        n_emax      = r_emax;
        n_emin      = r_emin;
        n_c         = r_c;
        n_k         = r_k;
        n_max_freq  = r_max_freq;
        n_min_freq  = r_min_freq;
        n_s1_k      = r_s1_k;
        n_s1_last   = r_s1_last;
        issue       = 1'b0;
        stop        = 1'b0;
        ev_en       = 1'b0;
        ev_prev     = r_w0;
        ev_cur      = r_w1;
        ev_next     = i_bm_rdata;
        ev_idx      = r_ri - BIN_AW'(1);
        o_pk_raddr  = r_k[SLOT_AW-1:0];
        o_mul_a     = s1_bin;
        o_pk_wr     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!full) begin
                        n_bin_count = r_bin_count + (BIN_AW+1)'(1);
                    end
                    if (i_word.last_bin) begin
                        n_last      = full ? '1 : r_bin_count[BIN_AW-1:0];
                        n_bin_count = '0;
                        n_ra        = '0;
                        n_iss       = 1'b1;
                        n_c         = CNT_W'(1);
                        n_emax      = '0;
                        n_emin      = '0;
                        n_state     = S_MAX;
                    end
                end
            end
            // stream the whole frame for the strongest bin
            S_MAX: begin
                if (r_iss) begin
                    issue = 1'b1;
                    if (r_ra == r_last) begin
                        n_iss = 1'b0;
                    end else begin
                        n_ra = r_ra + BIN_AW'(1);
                    end
                end
                if (r_rv) begin
                    if (r_ri == '0 || i_bm_rdata > r_best) begin
                        n_best = i_bm_rdata;
                        n_pm   = r_ri;
                    end
                    if (r_ri == r_last) begin
                        n_ra    = n_pm;
                        n_iss   = 1'b1;
                        n_state = S_WALK;
                    end
                end
            end
            // walk left from the strongest bin, reads run ahead of the test
            S_WALK: begin
                stop = r_rv && (r_ri == '0 || i_bm_rdata == '0);
                if (r_iss && !stop) begin
                    issue = 1'b1;
                    if (r_ra == '0) begin
                        n_iss = 1'b0;
                    end else begin
                        n_ra = r_ra - BIN_AW'(1);
                    end
                end
                if (stop) begin
                    if (r_ri == r_last) begin
                        n_iss   = 1'b0;
                        n_state = S_FMAX;
                    end else begin
                        n_sm1   = r_ri;
                        n_start = r_ri + BIN_AW'(1);
                        n_ra    = r_ri;
                        n_iss   = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            // scan from the bin left of the range start to the end
            S_SCAN: begin
                if (r_iss) begin
                    issue = 1'b1;
                    if (r_ra == r_last) begin
                        n_iss = 1'b0;
                    end else begin
                        n_ra = r_ra + BIN_AW'(1);
                    end
                end
                if (r_rv) begin
                    if (r_ri > r_sm1) begin
                        if (r_ri == r_start || i_bm_rdata > r_vmax) begin
                            n_vmax = i_bm_rdata;
                            n_emax = r_ri;
                        end
                        if (r_ri == r_start || i_bm_rdata < r_vmin) begin
                            n_vmin = i_bm_rdata;
                            n_emin = r_ri;
                        end
                    end
                    ev_en = (r_ri > r_start);
                    n_w0  = r_w1;
                    n_w1  = i_bm_rdata;
                    if (r_ri == r_last) begin
                        n_state = S_TAIL;
                    end
                end
            end
            // final bin, its right neighbour reads as zero
            S_TAIL: begin
                ev_en   = 1'b1;
                ev_next = '0;
                ev_idx  = r_last;
                n_state = S_FMAX;
            end
            S_FMAX: begin
                o_mul_a = r_emax;
                n_state = S_FMIN;
            end
            S_FMIN: begin
                o_mul_a    = r_emin;
                n_max_freq = i_prod;
                n_k        = '0;
                n_state    = S_EMIT;
            end
            // read one slot a cycle
            S_EMIT: begin
                if (r_k == '0) begin
                    n_min_freq = i_prod;
                end
                n_s1_vld  = 1'b1;
                n_s1_k    = r_k[SLOT_AW-1:0];
                n_s1_last = (r_k + CNT_W'(1) == r_c);
                if (r_k + CNT_W'(1) == r_c) begin
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + CNT_W'(1);
                end
            end
            S_DRAIN: begin
                if (r_o_vld && r_o_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // strict local maximum goes to the current slot
        if (ev_en && ev_prev < ev_cur && ev_cur > ev_next) begin
            o_pk_wr.we      = 1'b1;
            o_pk_wr.addr    = r_c[SLOT_AW-1:0];
            o_pk_wr.ent.bin = ev_idx;
            o_pk_wr.ent.pow = ev_cur;
            if (r_c + CNT_W'(1) < i_lim) begin
                n_c = r_c + CNT_W'(1);
            end
        end
    end

    assign n_rv     = issue;
    assign n_ri     = r_ra;
    assign n_o_vld  = r_s1_vld;
    assign n_o_slot = r_s1_k;
    assign n_o_bin  = s1_bin;
    assign n_o_pow  = s1_pow;
    assign n_o_last = r_s1_last;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bin_count <= '0;
            r_iss       <= 1'b0;
            r_rv        <= 1'b0;
            r_s1_vld    <= 1'b0;
            r_o_vld     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bin_count <= n_bin_count;
            r_iss       <= n_iss;
            r_rv        <= n_rv;
            r_s1_vld    <= n_s1_vld;
            r_o_vld     <= n_o_vld;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_last     <= n_last;
        r_ra       <= n_ra;
        r_ri       <= n_ri;
        r_best     <= n_best;
        r_pm       <= n_pm;
        r_sm1      <= n_sm1;
        r_start    <= n_start;
        r_w0       <= n_w0;
        r_w1       <= n_w1;
        r_vmax     <= n_vmax;
        r_vmin     <= n_vmin;
        r_emax     <= n_emax;
        r_emin     <= n_emin;
        r_c        <= n_c;
        r_k        <= n_k;
        r_max_freq <= n_max_freq;
        r_min_freq <= n_min_freq;
        r_s1_k     <= n_s1_k;
        r_s1_last  <= n_s1_last;
        r_o_slot   <= n_o_slot;
        r_o_bin    <= n_o_bin;
        r_o_pow    <= n_o_pow;
        r_o_last   <= n_o_last;
    end

    // result word
    assign o_strobe = r_o_vld;
    always_comb begin
        o_word.slot       = r_o_slot;
        o_word.peak_bin   = r_o_bin;
        o_word.peak_freq  = i_prod;
        o_word.peak_power = r_o_pow;
        o_word.peak_count = r_c;
        o_word.max_freq   = r_max_freq;
        o_word.min_freq   = r_min_freq;
        o_word.last       = r_o_last;
    end

    // checks
    a_strobe_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld |-> (r_state == S_EMIT || r_state == S_DRAIN))
        else $error("result word outside the readout");

    a_pk_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pk_wr.we |-> (o_pk_wr.addr != '0 && {1'b0, o_pk_wr.addr} < i_lim))
        else $error("peak written outside the slots in use");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_TAIL) |-> (r_c != '0 && r_c < i_lim))
        else $error("slot count out of range during scan");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_s1_vld && !r_rv))
        else $error("work in flight while idle");

    a_last_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_last) |=> !r_o_vld)
        else $error("word after the final slot");

endmodule

// ===== hw/rtl/spectrum_peak_picker_core.sv =====
`timescale 1ns / 1ps

// channel   handshake                         payload
// -------   -------------------------------   ----------------------------
// input     start & !busy                     i_word (bin_value, last_bin)
// result    o_strobe, one cycle per word      o_word (slot .. last)
// config    i_cfg_we                          i_cfg_idx, i_cfg_data
//
// a bin that does not close the frame is written to the bin store while it has room
// a closing bin starts the accept and max pass, the leftward walk, the scan (absent
// when the range is empty), the maximum and minimum frequencies and the slot readout,
// in that order, paced by the single read port of the bin store and the shared multiplier
// reset is synchronous and active low; bin and peak stores hold no reset value
// busy stays high from the closing bin to the final word; o_strobe cannot be stalled

module spectrum_peak_picker_core
    import spp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  t_in_word              i_word,
    output logic                  busy,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_strobe,
    output t_out_word             o_word
);

    logic [CNT_W-1:0]   r_max_peaks;
    logic [HZ_W-1:0]    r_hz;
    logic [CNT_W-1:0]   lim;

    logic               bm_we;
    logic [BIN_AW-1:0]  bm_waddr;
    logic [VAL_W-1:0]   bm_wdata;
    logic [BIN_AW-1:0]  bm_raddr;
    logic [VAL_W-1:0]   bm_rdata;
    t_pk_wr             pk_wr;
    logic [SLOT_AW-1:0] pk_raddr;
    t_pk_ent            pk_rdata;
    logic [BIN_AW-1:0]  mul_a;
    logic [FREQ_W-1:0]  prod;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_peaks <= MP_RESET;
            r_hz        <= HZ_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_PEAKS: r_max_peaks <= i_cfg_data[CNT_W-1:0];
                CFG_HZ:        r_hz        <= i_cfg_data[HZ_W-1:0];
                default:       r_hz        <= r_hz;
            endcase
        end
    end

    // slot limit clamped to the store
    always_comb begin
        if (r_max_peaks < LIM_LOW) begin
            lim = LIM_LOW;
        end else if (r_max_peaks > LIM_HIGH) begin
            lim = LIM_HIGH;
        end else begin
            lim = r_max_peaks;
        end
    end

    spp_bin_mem u_bin_mem (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    spp_peak_mem u_peak_mem (
        .i_clk   (i_clk),
        .i_wr    (pk_wr),
        .i_raddr (pk_raddr),
        .o_rdata (pk_rdata)
    );

    spp_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (r_hz),
        .o_p   (prod)
    );

    spp_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_word     (i_word),
        .o_busy     (busy),
        .i_lim      (lim),
        .o_bm_we    (bm_we),
        .o_bm_waddr (bm_waddr),
        .o_bm_wdata (bm_wdata),
        .o_bm_raddr (bm_raddr),
        .i_bm_rdata (bm_rdata),
        .o_pk_wr    (pk_wr),
        .o_pk_raddr (pk_raddr),
        .i_pk_rdata (pk_rdata),
        .o_mul_a    (mul_a),
        .i_prod     (prod),
        .o_strobe   (o_strobe),
        .o_word     (o_word)
    );

endmodule
